// File: rtl/core/rhms_pkg.sv
// ----------------------------------------------------------------------------
// rhms_pkg
// Types and constants shared by the return-home mission sequencer.
// ----------------------------------------------------------------------------
package rhms_pkg;

   typedef struct packed {
      logic               pose_valid;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [15:0] heading;
      logic [31:0]        now_ms;
   } req_type;

   typedef struct packed {
      logic               mission_active;
      logic [2:0]         mission_state;
      logic [1:0]         path_request;
      logic signed [15:0] path_heading;
      logic               course_valid;
      logic signed [15:0] course_heading;
   } rsp_type;

   // mission phases
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_OUT  = 3'd1;
   localparam logic [2:0] PH_TURN = 3'd2;
   localparam logic [2:0] PH_RET  = 3'd3;
   localparam logic [2:0] PH_DONE = 3'd4;

   // path requests
   localparam logic [1:0] REQ_NONE     = 2'd0;
   localparam logic [1:0] REQ_OUTBOUND = 2'd1;
   localparam logic [1:0] REQ_HOMEWARD = 2'd2;
   localparam logic [1:0] REQ_STOP     = 2'd3;

   // register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYPOINT_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYPOINT_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOME_X      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOME_Y      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_RADIUS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HOME_RADIUS = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_HOME_HTOL   = 3'd6;

   localparam logic [16:0] UTURN_TOL_BAM = 17'd1565;

   // CORDIC: 2^32 angle units per turn, inputs prescaled by 2^20
   localparam int ATAN_N      = 24;
   localparam int ITER_W      = $clog2(ATAN_N);
   localparam int PRESCALE_SH = 20;
   localparam int CW          = 49;
   localparam int CORDIC_PAD  = CW - 25 - PRESCALE_SH;
   localparam logic [31:0] Z_QUARTER       = 32'h4000_0000;
   localparam logic [31:0] Z_THREE_QUARTER = 32'hC000_0000;
   localparam logic [31:0] Z_ROUND         = 32'h0000_8000;

   localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef struct packed {
      logic load;
      logic step;
      logic sq_dx;
      logic sq_dy;
      logic sq_rad;
      logic compare;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic       pose_valid;
      logic [2:0] phase;
      logic       iter_last;
      logic       out_free;
   } status_type;

endpackage

// File: rtl/core/return_home_mission_sequencer_core.sv
// ----------------------------------------------------------------------------
// return_home_mission_sequencer_core
// Return-home mission sequencer: one pose beat in, at most one result out.
// The idle phase runs CORDIC_STEPS CORDIC iterations before the result register;
//   outbound/return use the shared squarer, other phases commit directly.
// Throughput: one pose at a time; next beat can be taken in the cycle after commit.
// A pending result does not block the next pose beat.
// Reset (synchronous): idle phase, registers to their reset values, no result.
// ----------------------------------------------------------------------------
module return_home_mission_sequencer_core #(
   parameter int CORDIC_STEPS    = 16,
   parameter int REPLAN_MS       = 3000,
   parameter int TURN_TIMEOUT_MS = 20000
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  rhms_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rhms_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rhms_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rhms_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   rhms_pkg::cmd_type    cmd;
   rhms_pkg::status_type status;

   assign csr_ready = 1'b1;

   rhms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rhms_dp #(
      .CORDIC_STEPS    (CORDIC_STEPS),
      .REPLAN_MS       (REPLAN_MS),
      .TURN_TIMEOUT_MS (TURN_TIMEOUT_MS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_valid && req_ready),
      .req_data   (req_data),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// File: rtl/core/rhms_ctrl.sv
// ----------------------------------------------------------------------------
// rhms_ctrl
// Sequencer: accepts a pose beat, runs CORDIC or distance steps, commits; drops a beat without pose_valid.
// ----------------------------------------------------------------------------
module rhms_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rhms_pkg::status_type  status,
   output rhms_pkg::cmd_type     cmd
);

   typedef enum logic [7:0] {
      ST_WAIT   = 8'b0000_0001,
      ST_LOAD   = 8'b0000_0010,
      ST_ITER   = 8'b0000_0100,
      ST_MUL0   = 8'b0000_1000,
      ST_MUL1   = 8'b0001_0000,
      ST_MUL2   = 8'b0010_0000,
      ST_CMP    = 8'b0100_0000,
      ST_COMMIT = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_WAIT: begin
            if (req_valid) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (!status.pose_valid) begin
               state_in = ST_WAIT;
            end else begin
               case (status.phase)
                  rhms_pkg::PH_IDLE: state_in = ST_ITER;
                  rhms_pkg::PH_OUT:  state_in = ST_MUL0;
                  rhms_pkg::PH_RET:  state_in = ST_MUL0;
                  default:           state_in = ST_COMMIT;
               endcase
            end
         end
         ST_ITER: begin
            if (status.iter_last) state_in = ST_COMMIT;
         end
         ST_MUL0:   state_in = ST_MUL1;
         ST_MUL1:   state_in = ST_MUL2;
         ST_MUL2:   state_in = ST_CMP;
         ST_CMP:    state_in = ST_COMMIT;
         ST_COMMIT: begin
            if (status.out_free) state_in = ST_WAIT;
         end
         default:   state_in = ST_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready   = (state_ff == ST_WAIT);
   assign cmd.load    = (state_ff == ST_LOAD);
   assign cmd.step    = (state_ff == ST_ITER);
   assign cmd.sq_dx   = (state_ff == ST_MUL0);
   assign cmd.sq_dy   = (state_ff == ST_MUL1);
   assign cmd.sq_rad  = (state_ff == ST_MUL2);
   assign cmd.compare = (state_ff == ST_CMP);
   assign cmd.commit  = (state_ff == ST_COMMIT) && status.out_free;

endmodule

// File: rtl/core/rhms_dp.sv
// ----------------------------------------------------------------------------
// rhms_dp
// Datapath: registers, mission state, CORDIC atan2, squared distance,
// phase decisions and the result register.
// ----------------------------------------------------------------------------
module rhms_dp #(
   parameter int CORDIC_STEPS    = 16,
   parameter int REPLAN_MS       = 3000,
   parameter int TURN_TIMEOUT_MS = 20000
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_accept,
   input  rhms_pkg::req_type                     req_data,
   input  logic                                  csr_write,
   input  logic [rhms_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rhms_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  rhms_pkg::cmd_type                     cmd,
   output rhms_pkg::status_type                  status,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output rhms_pkg::rsp_type                     rsp_data
);

   localparam int CW = rhms_pkg::CW;
   localparam int IW = rhms_pkg::ITER_W;

   // configuration
   logic signed [23:0] wp_x_ff, wp_y_ff, home_x_ff, home_y_ff;
   logic [19:0]        goal_rad_ff, home_rad_ff;
   logic [14:0]        htol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_x_ff     <= '0;
         wp_y_ff     <= '0;
         home_x_ff   <= '0;
         home_y_ff   <= '0;
         goal_rad_ff <= 20'd1500;
         home_rad_ff <= 20'd1500;
         htol_ff     <= 15'd2608;
      end else if (csr_write) begin
         case (csr_index)
            rhms_pkg::CSR_WAYPOINT_X:  wp_x_ff     <= csr_wdata;
            rhms_pkg::CSR_WAYPOINT_Y:  wp_y_ff     <= csr_wdata;
            rhms_pkg::CSR_HOME_X:      home_x_ff   <= csr_wdata;
            rhms_pkg::CSR_HOME_Y:      home_y_ff   <= csr_wdata;
            rhms_pkg::CSR_GOAL_RADIUS: goal_rad_ff <= csr_wdata[19:0];
            rhms_pkg::CSR_HOME_RADIUS: home_rad_ff <= csr_wdata[19:0];
            rhms_pkg::CSR_HOME_HTOL:   htol_ff     <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // pose beat
   rhms_pkg::req_type in_ff;

   always_ff @(posedge clock) begin
      if (req_accept) in_ff <= req_data;
   end

   // mission state
   logic [2:0]  phase_ff, phase_in;
   logic [15:0] out_dir_ff, out_dir_in;
   logic [15:0] ret_dir_ff, ret_dir_in;
   logic [31:0] turn_ms_ff, turn_ms_in;
   logic [31:0] replan_ms_ff, replan_ms_in;

   // distance operands
   logic signed [23:0] tgt_x, tgt_y;
   logic signed [24:0] ddx, ddy;
   logic [24:0]        adx_ff, ady_ff;

   assign tgt_x = (phase_ff == rhms_pkg::PH_RET) ? home_x_ff : wp_x_ff;
   assign tgt_y = (phase_ff == rhms_pkg::PH_RET) ? home_y_ff : wp_y_ff;
   assign ddx   = {in_ff.pos_x[23], in_ff.pos_x} - {tgt_x[23], tgt_x};
   assign ddy   = {in_ff.pos_y[23], in_ff.pos_y} - {tgt_y[23], tgt_y};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         adx_ff <= ddx[24] ? 25'(-ddx) : 25'(ddx);
         ady_ff <= ddy[24] ? 25'(-ddy) : 25'(ddy);
      end
   end

   // shared squarer
   logic [24:0] mul_a;
   logic [49:0] prod;
   logic [48:0] sqx_ff, sqy_ff;
   logic [39:0] rsq_ff;
   logic        dist_lt_ff;
   logic [19:0] rad;

   assign rad   = (phase_ff == rhms_pkg::PH_RET) ? home_rad_ff : goal_rad_ff;
   assign mul_a = cmd.sq_dx ? adx_ff : (cmd.sq_dy ? ady_ff : {5'd0, rad});
   assign prod  = mul_a * mul_a;

   always_ff @(posedge clock) begin
      if (cmd.sq_dx)   sqx_ff <= prod[48:0];
      if (cmd.sq_dy)   sqy_ff <= prod[48:0];
      if (cmd.sq_rad)  rsq_ff <= prod[39:0];
      if (cmd.compare) dist_lt_ff <= (({1'b0, sqx_ff} + {1'b0, sqy_ff}) < {10'd0, rsq_ff});
   end

   // CORDIC atan2, home to waypoint
   logic signed [24:0]   cdx, cdy;
   logic signed [CW-1:0] xe, ye, x0, y0;
   logic [31:0]          z0;
   logic signed [CW-1:0] cx_ff, cy_ff, cx_in, cy_in, xs, ys;
   logic [31:0]          cz_ff, cz_in, zr;
   logic                 czero_ff;
   logic [IW-1:0]        cnt_ff;
   logic [15:0]          cang;

   assign cdx = {wp_x_ff[23], wp_x_ff} - {home_x_ff[23], home_x_ff};
   assign cdy = {wp_y_ff[23], wp_y_ff} - {home_y_ff[23], home_y_ff};
   assign xe  = {{rhms_pkg::CORDIC_PAD{cdx[24]}}, cdx, {rhms_pkg::PRESCALE_SH{1'b0}}};
   assign ye  = {{rhms_pkg::CORDIC_PAD{cdy[24]}}, cdy, {rhms_pkg::PRESCALE_SH{1'b0}}};

   always_comb begin
      x0 = xe;
      y0 = ye;
      z0 = '0;
      if (cdx[24]) begin
         if (!cdy[24]) begin
            x0 = ye;
            y0 = -xe;
            z0 = rhms_pkg::Z_QUARTER;
         end else begin
            x0 = -ye;
            y0 = xe;
            z0 = rhms_pkg::Z_THREE_QUARTER;
         end
      end
   end

   assign xs = cx_ff >>> cnt_ff;
   assign ys = cy_ff >>> cnt_ff;

   always_comb begin
      if (!cy_ff[CW-1]) begin
         cx_in = cx_ff + ys;
         cy_in = cy_ff - xs;
         cz_in = cz_ff + rhms_pkg::ATAN_TAB[cnt_ff];
      end else begin
         cx_in = cx_ff - ys;
         cy_in = cy_ff + xs;
         cz_in = cz_ff - rhms_pkg::ATAN_TAB[cnt_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff    <= x0;
         cy_ff    <= y0;
         cz_ff    <= z0;
         czero_ff <= (cdx == '0) && (cdy == '0);
         cnt_ff   <= '0;
      end else if (cmd.step) begin
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
         cz_ff  <= cz_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign zr   = cz_ff + rhms_pkg::Z_ROUND;
   assign cang = czero_ff ? 16'd0 : zr[31:16];

   // phase decision
   logic [15:0] herr_d;
   logic [16:0] herr;
   logic        replan_due, turn_timeout;
   rhms_pkg::rsp_type rsp_in, rsp_ff;
   logic        rsp_valid_ff;

   assign herr_d       = in_ff.heading - ret_dir_ff;
   assign herr         = herr_d[15] ? (17'h10000 - {1'b0, herr_d}) : {1'b0, herr_d};
   assign replan_due   = (in_ff.now_ms - replan_ms_ff) > 32'(REPLAN_MS);
   assign turn_timeout = (in_ff.now_ms - turn_ms_ff) > 32'(TURN_TIMEOUT_MS);

   always_comb begin
      phase_in     = phase_ff;
      out_dir_in   = out_dir_ff;
      ret_dir_in   = ret_dir_ff;
      turn_ms_in   = turn_ms_ff;
      replan_ms_in = replan_ms_ff;
      rsp_in       = '0;
      rsp_in.mission_active = (phase_ff == rhms_pkg::PH_OUT) ||
                              (phase_ff == rhms_pkg::PH_TURN) ||
                              (phase_ff == rhms_pkg::PH_RET);
      case (phase_ff)
         rhms_pkg::PH_IDLE: begin
            out_dir_in          = cang;
            ret_dir_in          = cang + 16'h8000;
            rsp_in.path_request = rhms_pkg::REQ_OUTBOUND;
            rsp_in.path_heading = cang;
            phase_in            = rhms_pkg::PH_OUT;
         end
         rhms_pkg::PH_OUT: begin
            if (dist_lt_ff) begin
               turn_ms_in = in_ff.now_ms;
               phase_in   = rhms_pkg::PH_TURN;
            end else if (replan_due) begin
               rsp_in.path_request = rhms_pkg::REQ_OUTBOUND;
               rsp_in.path_heading = out_dir_ff;
               replan_ms_in        = in_ff.now_ms;
            end
         end
         rhms_pkg::PH_TURN: begin
            rsp_in.course_valid   = 1'b1;
            rsp_in.course_heading = ret_dir_ff;
            if ((herr < rhms_pkg::UTURN_TOL_BAM) || turn_timeout) begin
               rsp_in.path_request = rhms_pkg::REQ_HOMEWARD;
               rsp_in.path_heading = ret_dir_ff;
               replan_ms_in        = in_ff.now_ms;
               phase_in            = rhms_pkg::PH_RET;
            end
         end
         rhms_pkg::PH_RET: begin
            if (dist_lt_ff && (herr < {2'd0, htol_ff})) begin
               rsp_in.path_request = rhms_pkg::REQ_STOP;
               phase_in            = rhms_pkg::PH_DONE;
            end else if (replan_due) begin
               rsp_in.path_request = rhms_pkg::REQ_HOMEWARD;
               rsp_in.path_heading = ret_dir_ff;
               replan_ms_in        = in_ff.now_ms;
            end
         end
         default: phase_in = rhms_pkg::PH_DONE;
      endcase
      rsp_in.mission_state = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= rhms_pkg::PH_IDLE;
         out_dir_ff   <= '0;
         ret_dir_ff   <= '0;
         turn_ms_ff   <= '0;
         replan_ms_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            phase_ff     <= phase_in;
            out_dir_ff   <= out_dir_in;
            ret_dir_ff   <= ret_dir_in;
            turn_ms_ff   <= turn_ms_in;
            replan_ms_ff <= replan_ms_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data          = rsp_ff;
   assign status.pose_valid = in_ff.pose_valid;
   assign status.phase      = phase_ff;
   assign status.iter_last  = (cnt_ff == IW'(CORDIC_STEPS - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result committed over an untaken beat");

   a_phase_only_at_commit: assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> $stable(phase_ff))
      else $error("mission phase moved without a commit");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == rhms_pkg::PH_DONE) |=> (phase_ff == rhms_pkg::PH_DONE))
      else $error("left done phase");

   a_step_in_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (phase_ff == rhms_pkg::PH_IDLE))
      else $error("CORDIC step outside idle phase");

endmodule
